// ----- hw/rtl/jhtp_pkg.sv -----
package jhtp_pkg;

    // Offset counter width and the longest canonical code.
    localparam int OFFSET_BITS     = 20;
    localparam int MAX_CODE_LENGTH = 16;

    // Derived widths.
    localparam int CIDX_BITS  = $clog2(MAX_CODE_LENGTH);
    localparam int CLEN_BITS  = $clog2(MAX_CODE_LENGTH + 1);
    localparam int SUM_BITS   = $clog2(MAX_CODE_LENGTH * 255 + 1);
    localparam int CODE_BITS  = MAX_CODE_LENGTH + 1;

    // Command queue between the byte parser and the table unit.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Marker codes.
    localparam logic [7:0] MK_DHT = 8'hc4;
    localparam logic [7:0] MK_SOI = 8'hd8;
    localparam logic [7:0] MK_EOI = 8'hd9;
    localparam logic [7:0] MK_SOS = 8'hda;

    // Result kinds.
    localparam logic [1:0] EV_MARKER = 2'd0;
    localparam logic [1:0] EV_ENTRY  = 2'd1;
    localparam logic [1:0] EV_SCAN   = 2'd2;
    localparam logic [1:0] EV_END    = 2'd3;

    // Command opcodes.
    localparam logic [1:0] OP_EVENT  = 2'd0;
    localparam logic [1:0] OP_COUNT  = 2'd1;
    localparam logic [1:0] OP_SYMBOL = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]             event_kind;
        logic [OFFSET_BITS-1:0] byte_offset;
        logic [7:0]             marker_code;
        logic [7:0]             table_select;
        logic [CLEN_BITS-1:0]   code_length;
        logic [MAX_CODE_LENGTH-1:0] code_value;
        logic [7:0]             symbol_value;
        logic [7:0]             entry_index;
    } t_out_item;

    // One command from the parser to the table unit.
    typedef struct packed {
        logic [1:0]             op;
        logic [1:0]             kind;
        logic [OFFSET_BITS-1:0] offset;
        logic [7:0]             marker;
        logic [7:0]             table_sel;
        logic [7:0]             data;
        logic [CIDX_BITS-1:0]   cidx;
        logic                   last_count;
    } t_cmd;

endpackage

// ----- hw/rtl/jhtp_front.sv -----
module jhtp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  jhtp_pkg::t_in_item i_data,
    input  logic              i_q_full,
    output logic              o_ready,
    output logic              o_push,
    output jhtp_pkg::t_cmd    o_cmd
);
    import jhtp_pkg::*;

    localparam logic [3:0] PH_PREFIX = 4'd0;
    localparam logic [3:0] PH_CODE   = 4'd1;
    localparam logic [3:0] PH_LEN_HI = 4'd2;
    localparam logic [3:0] PH_LEN_LO = 4'd3;
    localparam logic [3:0] PH_SKIP   = 4'd4;
    localparam logic [3:0] PH_TSEL   = 4'd5;
    localparam logic [3:0] PH_COUNTS = 4'd6;
    localparam logic [3:0] PH_SYMS   = 4'd7;
    localparam logic [3:0] PH_DONE   = 4'd8;

    logic [3:0]             r_phase,    n_phase;
    logic [OFFSET_BITS-1:0] r_offset,   n_offset;
    logic [7:0]             r_marker,   n_marker;
    logic [15:0]            r_seg_rem,  n_seg_rem;
    logic [7:0]             r_len_high, n_len_high;
    logic [CIDX_BITS-1:0]   r_cidx,     n_cidx;
    logic [SUM_BITS-1:0]    r_sym_left, n_sym_left;
    logic [7:0]             r_table,    n_table;

    logic        accept;
    logic        cmd_valid;
    t_cmd        cmd;
    logic [7:0]  b;
    logic [15:0] seg_dec;
    logic [15:0] len_full;
    logic [SUM_BITS-1:0] sum_new;
    logic [SUM_BITS-1:0] left_dec;

    // Phase after a segment header or a finished table.
    function automatic logic [3:0] body_phase(input logic [15:0] rem, input logic [7:0] mk);
        logic [3:0] ph;
        if (rem == '0) begin
            ph = PH_PREFIX;
        end else if (mk == MK_DHT && rem > 16'(MAX_CODE_LENGTH)) begin
            ph = PH_TSEL;
        end else begin
            ph = PH_SKIP;
        end
        return ph;
    endfunction

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign b       = i_data.data_byte;

    // Classify the byte and work out the next parser state.
    always_comb begin
        n_phase    = r_phase;
        n_offset   = r_offset + OFFSET_BITS'(1);
        n_marker   = r_marker;
        n_seg_rem  = r_seg_rem;
        n_len_high = r_len_high;
        n_cidx     = r_cidx;
        n_sym_left = r_sym_left;
        n_table    = r_table;

        seg_dec  = (r_seg_rem != '0) ? r_seg_rem - 16'd1 : r_seg_rem;
        len_full = {r_len_high, b};
        sum_new  = r_sym_left + SUM_BITS'(b);
        left_dec = r_sym_left - SUM_BITS'(1);

        cmd_valid      = 1'b0;
        cmd            = '0;
        cmd.offset     = r_offset;
        cmd.marker     = r_marker;
        cmd.table_sel  = r_table;
        cmd.data       = b;
        cmd.cidx       = r_cidx;

        case (r_phase)
            PH_PREFIX: begin
                n_phase = PH_CODE;
            end
            PH_CODE: begin
                n_marker   = b;
                cmd_valid  = 1'b1;
                cmd.op     = OP_EVENT;
                cmd.kind   = EV_MARKER;
                cmd.offset = r_offset - OFFSET_BITS'(1);
                cmd.marker = b;
                if (b == MK_SOS) begin
                    cmd.kind = EV_SCAN;
                    n_phase  = PH_DONE;
                end else if (b == MK_SOI || b == MK_EOI) begin
                    n_phase = PH_PREFIX;
                end else begin
                    n_phase = PH_LEN_HI;
                end
            end
            PH_LEN_HI: begin
                n_len_high = b;
                n_phase    = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_seg_rem = (len_full >= 16'd2) ? len_full - 16'd2 : '0;
                n_phase   = body_phase(n_seg_rem, r_marker);
            end
            PH_SKIP: begin
                n_seg_rem = seg_dec;
                if (seg_dec == '0) begin
                    n_phase = PH_PREFIX;
                end
            end
            PH_TSEL: begin
                n_table    = b;
                n_seg_rem  = seg_dec;
                n_cidx     = '0;
                n_sym_left = '0;
                n_phase    = (seg_dec == '0) ? PH_PREFIX : PH_COUNTS;
            end
            PH_COUNTS: begin
                cmd_valid      = 1'b1;
                cmd.op         = OP_COUNT;
                cmd.last_count = (r_cidx == CIDX_BITS'(MAX_CODE_LENGTH - 1));
                n_cidx         = r_cidx + CIDX_BITS'(1);
                n_seg_rem      = seg_dec;
                n_sym_left     = sum_new;
                if (cmd.last_count) begin
                    if (sum_new == '0) begin
                        n_phase = body_phase(seg_dec, r_marker);
                    end else begin
                        n_phase = (seg_dec == '0) ? PH_PREFIX : PH_SYMS;
                    end
                end else if (seg_dec == '0) begin
                    n_phase = PH_PREFIX;
                end
            end
            PH_SYMS: begin
                cmd_valid  = 1'b1;
                cmd.op     = OP_SYMBOL;
                n_sym_left = left_dec;
                n_seg_rem  = seg_dec;
                if (left_dec == '0) begin
                    n_phase = body_phase(seg_dec, r_marker);
                end else if (seg_dec == '0) begin
                    n_phase = PH_PREFIX;
                end
            end
            default: begin
            end
        endcase

        // The final byte reports an early end unless the scan has started, and returns to the reset state.
        if (i_data.last_byte) begin
            if (r_phase != PH_DONE && !(cmd_valid && cmd.kind == EV_SCAN)) begin
                cmd_valid  = 1'b1;
                cmd        = '0;
                cmd.op     = OP_EVENT;
                cmd.kind   = EV_END;
                cmd.offset = r_offset;
                cmd.marker = n_marker;
            end
            n_phase    = PH_PREFIX;
            n_offset   = '0;
            n_marker   = '0;
            n_seg_rem  = '0;
            n_len_high = '0;
            n_cidx     = '0;
            n_sym_left = '0;
            n_table    = '0;
        end
    end

    assign o_push = accept && cmd_valid;
    assign o_cmd  = cmd;

    // Parser state advances on every input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_PREFIX;
            r_offset   <= '0;
            r_marker   <= '0;
            r_seg_rem  <= '0;
            r_len_high <= '0;
            r_cidx     <= '0;
            r_sym_left <= '0;
            r_table    <= '0;
        end else if (accept) begin
            r_phase    <= n_phase;
            r_offset   <= n_offset;
            r_marker   <= n_marker;
            r_seg_rem  <= n_seg_rem;
            r_len_high <= n_len_high;
            r_cidx     <= n_cidx;
            r_sym_left <= n_sym_left;
            r_table    <= n_table;
        end
    end

`ifndef SYNTHESIS
    // While symbols are expected, at least one remains in the table.
    a_syms_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SYMS) |-> (r_sym_left != '0))
        else $error("symbol phase with no symbols left");

    // The final byte of a file restarts parsing from offset zero.
    a_last_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_data.last_byte) |=> (r_phase == PH_PREFIX && r_offset == '0))
        else $error("parser did not restart after the final byte");
`endif

endmodule

// ----- hw/rtl/jhtp_queue.sv -----
module jhtp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  jhtp_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_head_valid,
    output jhtp_pkg::t_cmd o_head
);
    import jhtp_pkg::*;

    t_cmd                 r_slots [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_BITS-1:0] r_count,  n_count;

    assign o_full       = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_slots[r_rd_ptr];

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 :
                       r_wr_ptr + QPTR_BITS'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 :
                       r_rd_ptr + QPTR_BITS'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_BITS'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Command storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_cmd;
        end
    end

`ifndef SYNTHESIS
    // A command is only taken from a queue that holds one.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue popped while empty");

    // A lone transfer in raises the fill count by one.
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + QCNT_BITS'(1)))
        else $error("queue fill count out of step");
`endif

endmodule

// ----- hw/rtl/jhtp_back.sv -----
module jhtp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_head_valid,
    input  jhtp_pkg::t_cmd      i_head,
    output logic                o_pop,
    input  logic                i_ready,
    output logic                o_valid,
    output jhtp_pkg::t_out_item o_data
);
    import jhtp_pkg::*;

    // Table state: code counts per length and the code generator.
    logic [7:0]                 r_counts [MAX_CODE_LENGTH];
    logic [MAX_CODE_LENGTH-1:0] r_mask;
    logic [CLEN_BITS-1:0]       r_cidx;
    logic [CODE_BITS-1:0]       r_code;
    logic [7:0]                 r_left;
    logic [8:0]                 r_sym_idx;

    logic      r_out_valid;
    t_out_item r_out, n_out;

    logic                       needs_slot;
    logic                       can_emit;
    logic [MAX_CODE_LENGTH-1:0] new_mask;
    logic [CLEN_BITS-1:0]       first_len;
    logic [7:0]                 first_count;
    logic [MAX_CODE_LENGTH-1:0] above;
    logic [CLEN_BITS-1:0]       next_len;
    logic [CLEN_BITS-1:0]       shift;
    logic [CODE_BITS-1:0]       code_inc;
    logic [7:0]                 left_dec;

    // Lowest length with a nonzero count, or MAX_CODE_LENGTH when none.
    function automatic logic [CLEN_BITS-1:0] first_set(input logic [MAX_CODE_LENGTH-1:0] m);
        logic [CLEN_BITS-1:0] idx;
        idx = CLEN_BITS'(MAX_CODE_LENGTH);
        for (int i = MAX_CODE_LENGTH - 1; i >= 0; i--) begin
            if (m[i]) begin
                idx = CLEN_BITS'(i);
            end
        end
        return idx;
    endfunction

    assign needs_slot = (i_head.op == OP_EVENT) || (i_head.op == OP_SYMBOL);
    assign can_emit   = !r_out_valid || i_ready;
    assign o_pop      = i_head_valid && (!needs_slot || can_emit);

    // Length search when a table's counts are complete.
    always_comb begin
        new_mask = r_mask;
        new_mask[i_head.cidx] = (i_head.data != 8'd0);
        first_len = first_set(new_mask);
        if (first_len[CIDX_BITS-1:0] == i_head.cidx) begin
            first_count = i_head.data;
        end else begin
            first_count = r_counts[first_len[CIDX_BITS-1:0]];
        end
    end

    // Length search after the last code of the current length.
    always_comb begin
        for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
            above[i] = r_mask[i] && (CLEN_BITS'(i) > r_cidx);
        end
        next_len = first_set(above);
        shift    = next_len - r_cidx;
        code_inc = r_code + CODE_BITS'(1);
        left_dec = r_left - 8'd1;
    end

    // Result formed from the head command.
    always_comb begin
        n_out             = '0;
        n_out.byte_offset = i_head.offset;
        n_out.marker_code = i_head.marker;
        case (i_head.op)
            OP_SYMBOL: begin
                n_out.event_kind   = EV_ENTRY;
                n_out.table_select = i_head.table_sel;
                n_out.code_length  = r_cidx + CLEN_BITS'(1);
                n_out.code_value   = r_code[MAX_CODE_LENGTH-1:0];
                n_out.symbol_value = i_head.data;
                n_out.entry_index  = r_sym_idx[7:0];
            end
            default: begin
                n_out.event_kind = i_head.kind;
            end
        endcase
    end

    // Table and code generator updates.
    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.op == OP_COUNT) begin
            r_counts[i_head.cidx] <= i_head.data;
            r_mask                <= new_mask;
            if (i_head.last_count) begin
                r_cidx    <= first_len;
                r_code    <= '0;
                r_sym_idx <= '0;
                r_left    <= first_count;
            end
        end else if (o_pop && i_head.op == OP_SYMBOL) begin
            r_sym_idx <= r_sym_idx + 9'd1;
            if (left_dec == 8'd0) begin
                r_code <= code_inc << shift;
                r_cidx <= next_len;
                r_left <= r_counts[next_len[CIDX_BITS-1:0]];
            end else begin
                r_code <= code_inc;
                r_left <= left_dec;
            end
        end
    end

    // Output register: a new result loads when the slot is free or draining.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && needs_slot) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && needs_slot) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    // Symbols only arrive while a code length with codes left is selected.
    a_sym_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_head.op == OP_SYMBOL) |->
            (r_cidx < CLEN_BITS'(MAX_CODE_LENGTH) && r_left != 8'd0))
        else $error("symbol outside a valid code length");

    // A taken event or symbol always shows up at the output.
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && needs_slot) |=> r_out_valid)
        else $error("result lost at the output register");
`endif

endmodule

// ----- hw/rtl/jpeg_header_huffman_table_parser.sv -----
// Channel   Handshake           Payload (t_in_item / t_out_item)
// input     i_valid / o_ready   i_data: data_byte, last_byte
// output    o_valid / i_ready   o_data: event_kind, byte_offset, marker_code,
//                               table_select, code_length, code_value,
//                               symbol_value, entry_index
//
// One byte is taken per cycle while the queue has room; a result passes through
// the command queue and the output register. The byte parser updates its state
// per byte; the table unit forms a code and steps to the next length from a 16-bit length mask.
// A two-entry command queue and the output register let either side stall.
// Reset is synchronous, active low; no clearing pass is needed.
module jpeg_header_huffman_table_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  jhtp_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output jhtp_pkg::t_out_item o_data
);
    import jhtp_pkg::*;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_head_valid;
    t_cmd q_in;
    t_cmd q_head;

    // Byte parser: walks markers and segments, issues commands.
    jhtp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_data   (i_data),
        .i_q_full (q_full),
        .o_ready  (o_ready),
        .o_push   (q_push),
        .o_cmd    (q_in)
    );

    // Command queue between the two sides.
    jhtp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_cmd        (q_in),
        .i_pop        (q_pop),
        .o_full       (q_full),
        .o_head_valid (q_head_valid),
        .o_head       (q_head)
    );

    // Table unit: keeps code counts and generates canonical codes.
    jhtp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_head_valid),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_data       (o_data)
    );

endmodule

// ----- verif/jpeg_header_huffman_table_parser_tb.sv -----
module jpeg_header_huffman_table_parser_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import jhtp_pkg::*;

    localparam int RANDOM_ITEMS = 850;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 12;

    // Parser phases, one per kind of byte that the walker expects next.
    typedef enum logic [3:0] {
        ST_PREFIX,
        ST_CODE,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_SKIP,
        ST_CLASS,
        ST_COUNTS,
        ST_SYMBOLS,
        ST_SCAN
    } t_parse_state;

    // One directed byte, with a hand-written result where one is given.
    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_stim_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_data;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_data;

    // Expected results in arrival order.
    t_out_item pending_events[$];
    t_stim_row directed_rows[$];
    logic [7:0] file_bytes[$];

    int mismatch_count = 0;
    int items_sent = 0;
    int valid_gap_pct = 13;
    int ready_stall_pct = 75;
    bit long_table_done = 1'b0;

    // Shadow copy of the walker state.
    t_parse_state               parse_state;
    logic [OFFSET_BITS-1:0]     byte_pos;
    logic [7:0]                 seg_marker;
    logic [15:0]                body_left;
    logic [7:0]                 len_msb;
    logic [7:0]                 counts_per_len [MAX_CODE_LENGTH];
    logic [4:0]                 len_idx;
    logic [CODE_BITS-1:0]       next_code;
    logic [7:0]                 codes_left;
    logic [8:0]                 sym_count;
    logic [8:0]                 sym_sum;
    logic [7:0]                 class_id;

    jpeg_header_huffman_table_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic void reset_predictor();
        parse_state = ST_PREFIX;
        byte_pos    = '0;
        seg_marker  = '0;
        body_left   = '0;
        len_msb     = '0;
        for (int k = 0; k < MAX_CODE_LENGTH; k++) begin
            counts_per_len[k] = '0;
        end
        len_idx    = '0;
        next_code  = '0;
        codes_left = '0;
        sym_count  = '0;
        sym_sum    = '0;
        class_id   = '0;
    endfunction

    // Pass over code lengths that hold no symbols; the code still doubles at each.
    function automatic void skip_empty_lengths();
        while (len_idx < MAX_CODE_LENGTH && counts_per_len[len_idx[3:0]] == 8'd0) begin
            next_code = next_code << 1;
            len_idx   = len_idx + 5'd1;
        end
        if (len_idx < MAX_CODE_LENGTH) begin
            codes_left = counts_per_len[len_idx[3:0]];
        end
    endfunction

    // A DHT body long enough for a class byte and 16 counts holds another table.
    function automatic void open_segment_body();
        if (body_left == 16'd0) begin
            parse_state = ST_PREFIX;
        end else if (seg_marker == MK_DHT && body_left > 16'd16) begin
            parse_state = ST_CLASS;
        end else begin
            parse_state = ST_SKIP;
        end
    endfunction

    function automatic t_out_item make_event(input logic [1:0] kind,
                                             input logic [OFFSET_BITS-1:0] offset,
                                             input logic [7:0] marker,
                                             input logic [7:0] tsel,
                                             input logic [CLEN_BITS-1:0] clen,
                                             input logic [15:0] code,
                                             input logic [7:0] sym,
                                             input logic [7:0] index);
        t_out_item ev;
        ev.event_kind   = kind;
        ev.byte_offset  = offset;
        ev.marker_code  = marker;
        ev.table_select = tsel;
        ev.code_length  = clen;
        ev.code_value   = code;
        ev.symbol_value = sym;
        ev.entry_index  = index;
        return ev;
    endfunction

    // Advances the shadow state by one byte and returns 1 when the byte yields a result.
    function automatic bit predict_event(input t_in_item item, output t_out_item ev);
        logic [7:0]             b;
        logic [OFFSET_BITS-1:0] pos;
        logic [15:0]            seg_len;
        bit                     was_done;
        bit                     hit;
        int                     total;
        b        = item.data_byte;
        pos      = byte_pos;
        was_done = (parse_state == ST_SCAN);
        hit      = 1'b0;
        ev       = '0;
        case (parse_state)
            ST_PREFIX: begin
                parse_state = ST_CODE;
            end
            ST_CODE: begin
                seg_marker     = b;
                ev.byte_offset = pos - 1'b1;
                ev.marker_code = b;
                hit            = 1'b1;
                if (b == MK_SOS) begin
                    ev.event_kind = EV_SCAN;
                    parse_state   = ST_SCAN;
                end else if (b == MK_SOI || b == MK_EOI) begin
                    ev.event_kind = EV_MARKER;
                    parse_state   = ST_PREFIX;
                end else begin
                    ev.event_kind = EV_MARKER;
                    parse_state   = ST_LEN_HI;
                end
            end
            ST_LEN_HI: begin
                len_msb     = b;
                parse_state = ST_LEN_LO;
            end
            ST_LEN_LO: begin
                // The length counts its own two bytes; anything shorter is an empty body.
                seg_len   = {len_msb, b};
                body_left = (seg_len >= 16'd2) ? seg_len - 16'd2 : 16'd0;
                open_segment_body();
            end
            ST_SKIP: begin
                if (body_left > 16'd0) body_left = body_left - 16'd1;
                if (body_left == 16'd0) parse_state = ST_PREFIX;
            end
            ST_CLASS: begin
                class_id = b;
                if (body_left > 16'd0) body_left = body_left - 16'd1;
                len_idx     = '0;
                sym_sum     = '0;
                parse_state = (body_left == 16'd0) ? ST_PREFIX : ST_COUNTS;
            end
            ST_COUNTS: begin
                counts_per_len[len_idx[3:0]] = b;
                len_idx = len_idx + 5'd1;
                if (body_left > 16'd0) body_left = body_left - 16'd1;
                total   = int'(sym_sum) + int'(b);
                sym_sum = (total > 511) ? 9'd511 : 9'(total);
                if (len_idx >= MAX_CODE_LENGTH) begin
                    len_idx   = '0;
                    next_code = '0;
                    sym_count = '0;
                    if (sym_sum == 9'd0) begin
                        open_segment_body();
                    end else begin
                        skip_empty_lengths();
                        parse_state = (body_left == 16'd0) ? ST_PREFIX : ST_SYMBOLS;
                    end
                end else if (body_left == 16'd0) begin
                    parse_state = ST_PREFIX;
                end
            end
            ST_SYMBOLS: begin
                ev = make_event(EV_ENTRY, pos, seg_marker, class_id,
                                CLEN_BITS'(len_idx + 5'd1), next_code[15:0], b,
                                sym_count[7:0]);
                hit       = 1'b1;
                next_code = next_code + 1'b1;
                sym_count = sym_count + 9'd1;
                if (codes_left > 8'd0) codes_left = codes_left - 8'd1;
                if (body_left > 16'd0) body_left = body_left - 16'd1;
                if (codes_left == 8'd0) begin
                    next_code = next_code << 1;
                    len_idx   = len_idx + 5'd1;
                    skip_empty_lengths();
                end
                if (len_idx >= MAX_CODE_LENGTH) begin
                    open_segment_body();
                end else if (body_left == 16'd0) begin
                    parse_state = ST_PREFIX;
                end
            end
            default: begin
            end
        endcase
        byte_pos = pos + 1'b1;

        // The final byte reports an early end unless the scan had started, then clears.
        if (item.last_byte) begin
            if (!was_done && !(hit && ev.event_kind == EV_SCAN)) begin
                ev  = make_event(EV_END, pos, seg_marker, '0, '0, '0, '0, '0);
                hit = 1'b1;
            end
            reset_predictor();
        end
        return hit;
    endfunction

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want, input logic [31:0] offset);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0h, expected %0h (byte offset %0h)",
                                      name, got, want, offset));
        end
    endtask

    task automatic check_event(input t_out_item got);
        t_out_item   want;
        logic [31:0] off;
        if (pending_events.size() == 0) begin
            report_mismatch($sformatf("unexpected result, kind %0d at byte offset %0h",
                                      got.event_kind, got.byte_offset));
            return;
        end
        want = pending_events.pop_front();
        off  = 32'(want.byte_offset);
        check_field("event_kind", 32'(got.event_kind), 32'(want.event_kind), off);
        check_field("byte_offset", 32'(got.byte_offset), 32'(want.byte_offset), off);
        check_field("marker_code", 32'(got.marker_code), 32'(want.marker_code), off);
        check_field("table_select", 32'(got.table_select), 32'(want.table_select), off);
        check_field("code_length", 32'(got.code_length), 32'(want.code_length), off);
        check_field("code_value", 32'(got.code_value), 32'(want.code_value), off);
        check_field("symbol_value", 32'(got.symbol_value), 32'(want.symbol_value), off);
        check_field("entry_index", 32'(got.entry_index), 32'(want.entry_index), off);
    endtask

    // Result side: check each transfer and stall at random.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            check_event(o_data);
        end
        i_ready <= ($urandom_range(0, 99) >= ready_stall_pct);
    end

    // Ends the run when no transfer happens on either side for too long.
    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("Test completed with failures");
        $finish;
    end

    // Offers one byte, waits for its transfer and records what it should produce.
    task automatic send_byte(input t_in_item item, input bit typed, input t_out_item want);
        t_out_item ev;
        bit        produced;
        while ($urandom_range(0, 99) < valid_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= item;
        do @(posedge i_clk); while (!o_ready);
        produced = predict_event(item, ev);
        if (typed) begin
            pending_events.push_back(want);
        end else if (produced) begin
            pending_events.push_back(ev);
        end
        items_sent++;
    endtask

    task automatic add_row(input logic [7:0] data, input bit last, input bit typed,
                           input t_out_item want);
        t_stim_row row;
        row.item.data_byte = data;
        row.item.last_byte = last;
        row.typed          = typed;
        row.want           = want;
        directed_rows.push_back(row);
    endtask

    // The prefix byte is not checked, so it is sometimes not 0xff.
    task automatic push_marker(input logic [7:0] code);
        file_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'hff);
        file_bytes.push_back(code);
    endtask

    // DHT segment of one to three tables; the long form overflows the code and index.
    task automatic add_dht_segment(input bit overlong);
        logic [7:0] body[$];
        int         tables;
        int         total;
        int         cnt;
        int         seg_len;
        tables = overlong ? 1 : $urandom_range(1, 3);
        for (int t = 0; t < tables; t++) begin
            body.push_back(($urandom_range(0, 3) != 0) ?
                           {3'b000, 1'($urandom), 2'b00, 2'($urandom)} : 8'($urandom));
            total = 0;
            for (int k = 0; k < MAX_CODE_LENGTH; k++) begin
                if (overlong) begin
                    cnt = (k == 0 || k == 7) ? 130 : ((k == 15) ? 3 : 0);
                end else begin
                    cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
                    if (total + cnt > 20) cnt = 0;
                end
                body.push_back(8'(cnt));
                total += cnt;
            end
            repeat (total) body.push_back(8'($urandom));
        end
        // Sometimes the length cuts a table short or leaves bytes over.
        if (!overlong) begin
            case ($urandom_range(0, 5))
                0: repeat ($urandom_range(1, body.size() - 1)) void'(body.pop_back());
                1: repeat ($urandom_range(1, 20)) body.push_back(8'($urandom));
                default: begin
                end
            endcase
        end
        seg_len = body.size() + 2;
        push_marker(MK_DHT);
        file_bytes.push_back(8'(seg_len >> 8));
        file_bytes.push_back(8'(seg_len));
        foreach (body[i]) file_bytes.push_back(body[i]);
    endtask

    // Any other segment, skipped whole; the short form gives a length below two.
    task automatic add_plain_segment(input bit short_len);
        logic [7:0] code;
        int         n;
        code = 8'($urandom);
        while (code == MK_SOI || code == MK_EOI || code == MK_SOS || code == MK_DHT) begin
            code = 8'($urandom);
        end
        push_marker(code);
        n = short_len ? 0 : $urandom_range(0, 6);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(short_len ? 8'($urandom_range(0, 1)) : 8'(n + 2));
        repeat (n) file_bytes.push_back(8'($urandom));
    endtask

    // Builds one file: mostly well-formed segment chains, now and then plain noise.
    task automatic build_file();
        bit overlong;
        file_bytes.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 24)) file_bytes.push_back(8'($urandom));
            return;
        end
        push_marker(MK_SOI);
        repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    overlong = !long_table_done && items_sent >= 400;
                    if (overlong) long_table_done = 1'b1;
                    add_dht_segment(overlong);
                end
                5, 6, 7: add_plain_segment(1'b0);
                8: push_marker(($urandom_range(0, 1) == 0) ? MK_SOI : MK_EOI);
                default: add_plain_segment(1'b1);
            endcase
        end
        // The file ends at a scan start, at EOI, or anywhere at all.
        case ($urandom_range(0, 2))
            0: begin
                push_marker(MK_SOS);
                repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom));
            end
            1: push_marker(MK_EOI);
            default: repeat ($urandom_range(0, file_bytes.size() - 1)) begin
                void'(file_bytes.pop_back());
            end
        endcase
    endtask

    task automatic send_file();
        t_in_item item;
        for (int i = 0; i < file_bytes.size(); i++) begin
            item.data_byte = file_bytes[i];
            item.last_byte = (i == file_bytes.size() - 1);
            send_byte(item, 1'b0, '0);
        end
    endtask

    initial begin
        int random_sent;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data  <= '0;
        i_ready <= 1'b0;
        reset_predictor();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Scan start, then a final byte once parsing has ended: no result.
        add_row(8'hff, 1'b0, 1'b0, '0);
        add_row(MK_SOS, 1'b0, 1'b1, make_event(EV_SCAN, '0, MK_SOS, '0, '0, '0, '0, '0));
        add_row(8'h5a, 1'b1, 1'b0, '0);
        // DHT with a length of one: the body is empty.
        add_row(8'h00, 1'b0, 1'b0, '0);
        add_row(MK_DHT, 1'b0, 1'b1, make_event(EV_MARKER, '0, MK_DHT, '0, '0, '0, '0, '0));
        add_row(8'h00, 1'b0, 1'b0, '0);
        add_row(8'h01, 1'b0, 1'b0, '0);
        // One table whose only code is 16 bits long.
        add_row(8'hff, 1'b0, 1'b0, '0);
        add_row(MK_DHT, 1'b0, 1'b1,
                make_event(EV_MARKER, OFFSET_BITS'(4), MK_DHT, '0, '0, '0, '0, '0));
        add_row(8'h00, 1'b0, 1'b0, '0);
        add_row(8'h14, 1'b0, 1'b0, '0);
        add_row(8'h11, 1'b0, 1'b0, '0);
        repeat (15) add_row(8'h00, 1'b0, 1'b0, '0);
        add_row(8'h01, 1'b0, 1'b0, '0);
        add_row(8'hff, 1'b0, 1'b1,
                make_event(EV_ENTRY, OFFSET_BITS'(25), MK_DHT, 8'h11, CLEN_BITS'(16),
                           '0, 8'hff, '0));
        // The file ends on an EOI code byte before any scan.
        add_row(8'hff, 1'b0, 1'b0, '0);
        add_row(MK_EOI, 1'b1, 1'b1,
                make_event(EV_END, OFFSET_BITS'(27), MK_EOI, '0, '0, '0, '0, '0));

        foreach (directed_rows[r]) begin
            send_byte(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
        end

        // Random files under three idling patterns.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent < 300) begin
                valid_gap_pct   = 13;
                ready_stall_pct = 75;
            end else if (random_sent < 575) begin
                valid_gap_pct   = 75;
                ready_stall_pct = 13;
            end else begin
                valid_gap_pct   = 0;
                ready_stall_pct = 0;
            end
            build_file();
            send_file();
            random_sent = items_sent - directed_rows.size();
        end
        i_valid <= 1'b0;

        // Drain the remaining results; the stall counter guards against a hang.
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
